FILE: design/chem_pkg.sv
// Shared types and constants for the co-occurrence histogram engine.
package chem_pkg;

    localparam int LEVEL_BITS    = 4;
    localparam int SUM_IDX_BITS  = 5;
    localparam int DIFF_IDX_BITS = 4;
    localparam int OUT_BITS      = 16;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Result load request from the sequencer to the output stage.
    typedef struct packed {
        logic load;
        logic is_query;
        logic pair_ok;
        logic sum_ok;
        logic diff_ok;
        logic x_ok;
        logic y_ok;
        logic symmetric;
        logic overflow;
    } t_res_ctl;

endpackage

FILE: design/chem_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module chem_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/chem_out.sv
// Output stage: formats one result word and holds it until the receiver takes it.
module chem_out #(
    parameter int COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chem_pkg::t_res_ctl          i_ctl,
    input  logic [COUNT_BITS-1:0]       i_pair_rd,
    input  logic [COUNT_BITS-1:0]       i_sum_rd,
    input  logic [COUNT_BITS-1:0]       i_diff_rd,
    input  logic [COUNT_BITS-1:0]       i_x_rd,
    input  logic [COUNT_BITS-1:0]       i_y_rd,
    input  logic [COUNT_BITS-1:0]       i_pairs_added,
    input  logic                        i_out_ready,
    output logic                        o_free,
    output logic                        o_out_valid,
    output logic [chem_pkg::OUT_BITS-1:0] o_pair_count,
    output logic [chem_pkg::OUT_BITS-1:0] o_sum_count,
    output logic [chem_pkg::OUT_BITS-1:0] o_diff_count,
    output logic [chem_pkg::OUT_BITS-1:0] o_x_count,
    output logic [chem_pkg::OUT_BITS-1:0] o_y_count,
    output logic [chem_pkg::OUT_BITS-1:0] o_total_pairs,
    output logic                        o_saturated
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                          r_valid;
    logic [chem_pkg::OUT_BITS-1:0] r_pair;
    logic [chem_pkg::OUT_BITS-1:0] r_sum;
    logic [chem_pkg::OUT_BITS-1:0] r_diff;
    logic [chem_pkg::OUT_BITS-1:0] r_x;
    logic [chem_pkg::OUT_BITS-1:0] r_y;
    logic [chem_pkg::OUT_BITS-1:0] r_total;
    logic                          r_sat;
    logic [COUNT_BITS:0]           dbl;
    logic [COUNT_BITS-1:0]         total;

    // Double the pair total in symmetric mode, clamped at the counter maximum.
    assign dbl   = {i_pairs_added, 1'b0};
    assign total = !i_ctl.symmetric ? i_pairs_added :
                   (dbl[COUNT_BITS] ? CNT_MAX : dbl[COUNT_BITS-1:0]);

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pair  <= (i_ctl.is_query && i_ctl.pair_ok) ?
                       chem_pkg::OUT_BITS'(i_pair_rd) : '0;
            r_sum   <= (i_ctl.is_query && i_ctl.sum_ok) ?
                       chem_pkg::OUT_BITS'(i_sum_rd) : '0;
            r_diff  <= (i_ctl.is_query && i_ctl.diff_ok) ?
                       chem_pkg::OUT_BITS'(i_diff_rd) : '0;
            r_x     <= (i_ctl.is_query && i_ctl.x_ok) ?
                       chem_pkg::OUT_BITS'(i_x_rd) : '0;
            r_y     <= (i_ctl.is_query && i_ctl.y_ok) ?
                       chem_pkg::OUT_BITS'(i_y_rd) : '0;
            r_total <= chem_pkg::OUT_BITS'(total);
            r_sat   <= i_ctl.overflow;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_pair_count  = r_pair;
    assign o_sum_count   = r_sum;
    assign o_diff_count  = r_diff;
    assign o_x_count     = r_x;
    assign o_y_count     = r_y;
    assign o_total_pairs = r_total;
    assign o_saturated   = r_sat;

endmodule

FILE: design/cooccurrence_histogram_engine_core.sv
// Top level: sequencer and count memories of the co-occurrence histogram engine.
//
// Input channel (i_in_valid / o_in_ready) takes one word per item: func selects
// clear, add pixel pair, query or no operation. Output channel (o_out_valid /
// i_out_ready) returns exactly one result word per item. Symmetric mode is set
// through i_cfg_wr_en / i_cfg_wr_data; the user writes it only while the block
// is idle, and the block itself does not enforce this.
// Each store is a synchronous RAM; an item runs through the sequencer states:
//   query: one read step (ST_RD), then the final step (ST_FIN)
//   add: read (ST_RD), write (ST_WR), then ST_FIN; symmetric add runs a second
//     read-modify-write pass for the swapped pair before ST_FIN
//   clear: sweeps GRAY_LEVELS*GRAY_LEVELS addresses, one per cycle, then reports
// Every pass does one read and one write on the pair-matrix RAM port.
// After reset the same sweep zeroes all stores with o_in_ready low and no
// result; configuration writes are taken throughout.
// A result word sits in the output register while the receiver stalls; the
// block still accepts the next item and holds that item's result in its final
// step until the output register frees up.
module cooccurrence_histogram_engine_core #(
    parameter int GRAY_LEVELS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [chem_pkg::LEVEL_BITS-1:0]     i_ref_level,
    input  logic [chem_pkg::LEVEL_BITS-1:0]     i_nbr_level,
    input  logic [chem_pkg::SUM_IDX_BITS-1:0]   i_sum_index,
    input  logic [chem_pkg::DIFF_IDX_BITS-1:0]  i_diff_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [chem_pkg::OUT_BITS-1:0]       o_pair_count,
    output logic [chem_pkg::OUT_BITS-1:0]       o_sum_count,
    output logic [chem_pkg::OUT_BITS-1:0]       o_diff_count,
    output logic [chem_pkg::OUT_BITS-1:0]       o_x_count,
    output logic [chem_pkg::OUT_BITS-1:0]       o_y_count,
    output logic [chem_pkg::OUT_BITS-1:0]       o_total_pairs,
    output logic                                o_saturated
);

    localparam int LW     = $clog2(GRAY_LEVELS);
    localparam int PDEPTH = GRAY_LEVELS * GRAY_LEVELS;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int SBINS  = 2 * GRAY_LEVELS - 1;
    localparam int SAW    = $clog2(SBINS);
    localparam int CB     = COUNT_BITS;
    localparam logic [CB-1:0]  CNT_MAX  = {CB{1'b1}};
    localparam logic [PAW-1:0] CLR_LAST = PAW'(PDEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_FIN
    } t_state;

    t_state          r_state;
    chem_pkg::t_func r_func;
    logic [LW-1:0]   r_a;
    logic [LW-1:0]   r_b;
    logic [chem_pkg::SUM_IDX_BITS-1:0]  r_sidx;
    logic [chem_pkg::DIFF_IDX_BITS-1:0] r_didx;
    logic            r_a_ok;
    logic            r_b_ok;
    logic            r_s_ok;
    logic            r_d_ok;
    logic            r_pass;
    logic            r_boot;
    logic            r_sym;
    logic [PAW-1:0]  r_clr;
    logic [CB-1:0]   r_pairs;
    logic            r_ovf;

    logic            in_acc;
    logic            in_ref_ok;
    logic            in_nbr_ok;
    logic            out_free;
    logic            is_add;
    logic            clearing;
    logic            last_pass;
    logic [PAW-1:0]  pair_addr;
    logic [SAW-1:0]  sum_addr;
    logic [LW-1:0]   diff_addr;
    logic [LW-1:0]   abs_diff;
    logic [PAW-1:0]  pair_wa;
    logic [SAW-1:0]  sum_wa;
    logic [LW-1:0]   diff_wa;
    logic [LW-1:0]   x_wa;
    logic [LW-1:0]   y_wa;
    logic            rd_en;
    logic            wr_pair;
    logic            wr_sum;
    logic            wr_lvl;
    logic [CB-1:0]   pair_rd;
    logic [CB-1:0]   sum_rd;
    logic [CB-1:0]   diff_rd;
    logic [CB-1:0]   x_rd;
    logic [CB-1:0]   y_rd;
    logic [CB:0]     pair_inc;
    logic [CB:0]     sum_inc;
    logic [CB:0]     diff_inc;
    logic [CB:0]     x_inc;
    logic [CB:0]     y_inc;
    logic [CB:0]     tot_inc;
    logic [CB-1:0]   pair_wd;
    logic [CB-1:0]   sum_wd;
    logic [CB-1:0]   diff_wd;
    logic [CB-1:0]   x_wd;
    logic [CB-1:0]   y_wd;
    logic            hit_any;
    chem_pkg::t_res_ctl res_ctl;

    // Saturating increment: {hit, next}.
    function automatic logic [CB:0] sat_inc(input logic [CB-1:0] c);
        logic [CB:0] res;
        if (c == CNT_MAX) begin
            res = {1'b1, CNT_MAX};
        end else begin
            res = {1'b0, c + CB'(1)};
        end
        return res;
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_ref_ok  = 32'(i_ref_level) < GRAY_LEVELS;
    assign in_nbr_ok  = 32'(i_nbr_level) < GRAY_LEVELS;

    assign is_add    = (r_func == chem_pkg::FUNC_ADD);
    assign clearing  = (r_state == ST_CLEAR);
    assign last_pass = r_pass || !r_sym;

    // Item addresses; the current pass holds its levels in r_a / r_b.
    assign abs_diff  = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
    assign pair_addr = PAW'(32'(r_a) * GRAY_LEVELS + 32'(r_b));
    assign sum_addr  = is_add ? SAW'(32'(r_a) + 32'(r_b)) : SAW'(32'(r_sidx));
    assign diff_addr = is_add ? abs_diff : LW'(32'(r_didx));

    assign pair_wa = clearing ? r_clr : pair_addr;
    assign sum_wa  = clearing ? r_clr[SAW-1:0] : sum_addr;
    assign diff_wa = clearing ? r_clr[LW-1:0] : diff_addr;
    assign x_wa    = clearing ? r_clr[LW-1:0] : r_a;
    assign y_wa    = clearing ? r_clr[LW-1:0] : r_b;

    assign rd_en   = (r_state == ST_RD);
    assign wr_pair = clearing || (r_state == ST_WR);
    assign wr_sum  = clearing ? (32'(r_clr) < SBINS) : (r_state == ST_WR);
    assign wr_lvl  = clearing ? (32'(r_clr) < GRAY_LEVELS) : (r_state == ST_WR);

    assign pair_inc = sat_inc(pair_rd);
    assign sum_inc  = sat_inc(sum_rd);
    assign diff_inc = sat_inc(diff_rd);
    assign x_inc    = sat_inc(x_rd);
    assign y_inc    = sat_inc(y_rd);
    assign tot_inc  = sat_inc(r_pairs);
    assign hit_any  = pair_inc[CB] | sum_inc[CB] | diff_inc[CB] | x_inc[CB] | y_inc[CB];

    assign pair_wd = clearing ? '0 : pair_inc[CB-1:0];
    assign sum_wd  = clearing ? '0 : sum_inc[CB-1:0];
    assign diff_wd = clearing ? '0 : diff_inc[CB-1:0];
    assign x_wd    = clearing ? '0 : x_inc[CB-1:0];
    assign y_wd    = clearing ? '0 : y_inc[CB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_sym <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_boot  <= 1'b1;
            r_clr   <= '0;
            r_pairs <= '0;
            r_ovf   <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr == CLR_LAST) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? ST_IDLE : ST_FIN;
                    end else begin
                        r_clr <= r_clr + PAW'(1);
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_func <= chem_pkg::t_func'(i_func);
                        r_a    <= LW'(32'(i_ref_level));
                        r_b    <= LW'(32'(i_nbr_level));
                        r_sidx <= i_sum_index;
                        r_didx <= i_diff_index;
                        r_a_ok <= in_ref_ok;
                        r_b_ok <= in_nbr_ok;
                        r_s_ok <= 32'(i_sum_index) < SBINS;
                        r_d_ok <= 32'(i_diff_index) < GRAY_LEVELS;
                        r_pass <= 1'b0;
                        case (chem_pkg::t_func'(i_func))
                            chem_pkg::FUNC_CLEAR: begin
                                r_clr   <= '0;
                                r_pairs <= '0;
                                r_ovf   <= 1'b0;
                                r_state <= ST_CLEAR;
                            end
                            chem_pkg::FUNC_ADD: begin
                                r_state <= (in_ref_ok && in_nbr_ok) ? ST_RD : ST_FIN;
                            end
                            chem_pkg::FUNC_QUERY: begin
                                r_state <= ST_RD;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    r_state <= is_add ? ST_WR : ST_FIN;
                end
                ST_WR: begin
                    // Write-back lands before the swapped pass reads again.
                    r_ovf <= r_ovf | hit_any | (last_pass & tot_inc[CB]);
                    if (last_pass) begin
                        r_pairs <= tot_inc[CB-1:0];
                        r_state <= ST_FIN;
                    end else begin
                        r_a     <= r_b;
                        r_b     <= r_a;
                        r_pass  <= 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res_ctl.load      = (r_state == ST_FIN) && out_free;
        res_ctl.is_query  = (r_func == chem_pkg::FUNC_QUERY);
        res_ctl.pair_ok   = r_a_ok && r_b_ok;
        res_ctl.sum_ok    = r_s_ok;
        res_ctl.diff_ok   = r_d_ok;
        res_ctl.x_ok      = r_a_ok;
        res_ctl.y_ok      = r_b_ok;
        res_ctl.symmetric = r_sym;
        res_ctl.overflow  = r_ovf;
    end

    chem_ram #(.DEPTH(PDEPTH), .WIDTH(CB), .AW(PAW)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (wr_pair),
        .i_waddr (pair_wa),
        .i_wdata (pair_wd),
        .i_re    (rd_en),
        .i_raddr (pair_addr),
        .o_rdata (pair_rd)
    );

    chem_ram #(.DEPTH(SBINS), .WIDTH(CB), .AW(SAW)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (wr_sum),
        .i_waddr (sum_wa),
        .i_wdata (sum_wd),
        .i_re    (rd_en),
        .i_raddr (sum_addr),
        .o_rdata (sum_rd)
    );

    chem_ram #(.DEPTH(GRAY_LEVELS), .WIDTH(CB), .AW(LW)) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (wr_lvl),
        .i_waddr (diff_wa),
        .i_wdata (diff_wd),
        .i_re    (rd_en),
        .i_raddr (diff_addr),
        .o_rdata (diff_rd)
    );

    chem_ram #(.DEPTH(GRAY_LEVELS), .WIDTH(CB), .AW(LW)) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (wr_lvl),
        .i_waddr (x_wa),
        .i_wdata (x_wd),
        .i_re    (rd_en),
        .i_raddr (r_a),
        .o_rdata (x_rd)
    );

    chem_ram #(.DEPTH(GRAY_LEVELS), .WIDTH(CB), .AW(LW)) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (wr_lvl),
        .i_waddr (y_wa),
        .i_wdata (y_wd),
        .i_re    (rd_en),
        .i_raddr (r_b),
        .o_rdata (y_rd)
    );

    chem_out #(.COUNT_BITS(CB)) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (res_ctl),
        .i_pair_rd     (pair_rd),
        .i_sum_rd      (sum_rd),
        .i_diff_rd     (diff_rd),
        .i_x_rd        (x_rd),
        .i_y_rd        (y_rd),
        .i_pairs_added (r_pairs),
        .i_out_ready   (i_out_ready),
        .o_free        (out_free),
        .o_out_valid   (o_out_valid),
        .o_pair_count  (o_pair_count),
        .o_sum_count   (o_sum_count),
        .o_diff_count  (o_diff_count),
        .o_x_count     (o_x_count),
        .o_y_count     (o_y_count),
        .o_total_pairs (o_total_pairs),
        .o_saturated   (o_saturated)
    );

endmodule

FILE: design/chem_checker.sv
// Port-level checks for the co-occurrence histogram engine, bound to the top level.
module chem_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_wr_en,
    input logic                                i_cfg_wr_data,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [1:0]                          i_func,
    input logic [chem_pkg::LEVEL_BITS-1:0]     i_ref_level,
    input logic [chem_pkg::LEVEL_BITS-1:0]     i_nbr_level,
    input logic [chem_pkg::SUM_IDX_BITS-1:0]   i_sum_index,
    input logic [chem_pkg::DIFF_IDX_BITS-1:0]  i_diff_index,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [chem_pkg::OUT_BITS-1:0]       o_pair_count,
    input logic [chem_pkg::OUT_BITS-1:0]       o_sum_count,
    input logic [chem_pkg::OUT_BITS-1:0]       o_diff_count,
    input logic [chem_pkg::OUT_BITS-1:0]       o_x_count,
    input logic [chem_pkg::OUT_BITS-1:0]       o_y_count,
    input logic [chem_pkg::OUT_BITS-1:0]       o_total_pairs,
    input logic                                o_saturated
);

    // Reset starts the clearing sweep: no intake and no result word.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or valid high right after reset");

    // One item at a time: intake closes right after a word is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while an item is in flight");

    // A new result word comes only from the final step of an item.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result word appeared while idle");

    // Hold a stalled result word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_total_pairs)
            && $stable(o_pair_count) && $stable(o_saturated))
        else $error("stalled result word changed");

endmodule

bind cooccurrence_histogram_engine_core chem_checker u_chem_checker (.*);
